[rtl/thjp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thjp_pkg: shared types and constants for the tensor header parser.
// Holds the record kinds, error codes, parser modes and the payload and
// queue entry structs used by the front and back parts.
// ----------------------------------------------------------------------------
package thjp_pkg;

  localparam int unsigned DefaultMaxSkipDepth = 255;

  typedef enum logic [2:0] {
    KIND_KEYBYTE = 3'd0,
    KIND_KEYEND  = 3'd1,
    KIND_DIM     = 3'd2,
    KIND_TENSOR  = 3'd3,
    KIND_DONE    = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_DTYPE     = 2'd1,
    ERR_MALFORMED = 2'd2,
    ERR_EARLY_END = 2'd3
  } err_e;

  typedef enum logic [4:0] {
    M_OPEN, M_KEYWAIT, M_KEY, M_KEYCOLON, M_KEYVAL, M_META,
    M_FIELDWAIT, M_FIELDNAME, M_FIELDCOLON, M_FIELDVAL, M_DTYPESTR,
    M_SHAPE, M_OFF_A, M_OFF_B, M_OFF_C, M_OFF_D, M_SKIPFIELD, M_DONE, M_ERR
  } mode_e;

  // Byte class decided by the front part.
  typedef enum logic [3:0] {
    CL_OTHER, CL_BLANK, CL_DIGIT, CL_LBRACE, CL_RBRACE, CL_QUOTE,
    CL_BSLASH, CL_COLON, CL_COMMA, CL_LBRACK, CL_RBRACK
  } class_e;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       last_byte;
    class_e     cls;
  } tok_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [63:0] byte_count;
    logic [2:0]  dtype_code;
    logic        complete;
    logic [7:0]  rank;
    logic        is_metadata;
    logic [1:0]  error_code;
  } out_beat_t;

  // Character of a known word at a position, 8'h00 beyond its end.
  function automatic logic [7:0] word_char(input logic [3:0] w, input logic [3:0] p);
    logic [95:0] s;
    logic [3:0]  len;
    logic [7:0]  c;
    s = '0;
    len = 4'd0;
    c = 8'h00;
    case (w)
      4'd0: begin s = "__metadata__"; len = 4'd12; end
      4'd1: begin s = {56'h0, "dtype"}; len = 4'd5; end
      4'd2: begin s = {56'h0, "shape"}; len = 4'd5; end
      4'd3: begin s = {"data_", "offsets"}; len = 4'd12; end
      4'd4: begin s = {64'h0, "BF16"}; len = 4'd4; end
      4'd5: begin s = {72'h0, "F32"}; len = 4'd3; end
      4'd6: begin s = {72'h0, "F16"}; len = 4'd3; end
      4'd7: begin s = {72'h0, "I32"}; len = 4'd3; end
      4'd8: begin s = {72'h0, "I64"}; len = 4'd3; end
      default: begin s = '0; len = 4'd0; end
    endcase
    if (p < len) begin
      c = s[8*(len - p - 4'd1) +: 8];
    end
    return c;
  endfunction

  function automatic logic [3:0] word_len(input logic [3:0] w);
    logic [3:0] l;
    case (w)
      4'd0, 4'd3: l = 4'd12;
      4'd1, 4'd2: l = 4'd5;
      4'd4:       l = 4'd4;
      default:    l = 4'd3;
    endcase
    return l;
  endfunction

endpackage : thjp_pkg
`default_nettype wire

[rtl/thjp_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thjp_stream_if: valid/ready channel with a typed payload.
// The source drives valid and payload, the sink drives ready.
// ----------------------------------------------------------------------------
interface thjp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface : thjp_stream_if
`default_nettype wire

[rtl/thjp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thjp_front: input stage and byte classifier.
// Registers each accepted beat together with its character class.
// ----------------------------------------------------------------------------
module thjp_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire thjp_pkg::in_beat_t in_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output thjp_pkg::tok_t         tok_o,
  output logic                   tok_valid_o,
  input  wire logic              tok_ready_i
);
  import thjp_pkg::*;

  logic   valid_q;
  tok_t   tok_q;
  class_e cls;

  // Classify the incoming byte.
  always_comb begin
    unique case (in_i.header_byte)
      8'h20, 8'h09, 8'h0A, 8'h0D: cls = CL_BLANK;
      8'h7B: cls = CL_LBRACE;
      8'h7D: cls = CL_RBRACE;
      8'h22: cls = CL_QUOTE;
      8'h5C: cls = CL_BSLASH;
      8'h3A: cls = CL_COLON;
      8'h2C: cls = CL_COMMA;
      8'h5B: cls = CL_LBRACK;
      8'h5D: cls = CL_RBRACK;
      default: begin
        if (in_i.header_byte >= 8'h30 && in_i.header_byte <= 8'h39) cls = CL_DIGIT;
        else cls = CL_OTHER;
      end
    endcase
  end

  assign in_ready_o  = !valid_q || tok_ready_i;
  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;

  // Pipeline register for one classified beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tok_q <= '{header_byte: in_i.header_byte, last_byte: in_i.last_byte, cls: cls};
    end
  end
endmodule : thjp_front
`default_nettype wire

[rtl/thjp_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thjp_fifo: two-entry queue between front and back parts.
// Full throughput with registered ready toward the front.
// ----------------------------------------------------------------------------
module thjp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire thjp_pkg::tok_t wr_i,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  output thjp_pkg::tok_t      rd_o,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i
);
  import thjp_pkg::*;

  tok_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_o       = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_i;
  end
endmodule : thjp_fifo
`default_nettype wire

[rtl/thjp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thjp_back: parser state machine and output register.
// Consumes one classified beat per cycle while the output register is free or
// being read, and produces at most one record per beat.
module thjp_back #(
  parameter int unsigned MaxSkipDepth = thjp_pkg::DefaultMaxSkipDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire thjp_pkg::tok_t tok_i,
  input  wire logic           tok_valid_i,
  output logic                tok_ready_o,
  output thjp_pkg::out_beat_t out_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i
);
  import thjp_pkg::*;

  localparam int unsigned DepthW = $clog2(MaxSkipDepth + 1);

  mode_e             mode_q, mode_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [63:0]       acc_q, acc_d, start_q, start_d, len_q, len_d;
  logic [3:0]        pos_q, pos_d;
  logic [7:0]        cand_q, cand_d;
  logic              esc_q, esc_d;
  logic [2:0]        seen_q, seen_d, dt_q, dt_d;
  logic [7:0]        rank_q, rank_d;
  logic              dig_q, dig_d;

  logic              ovalid_q;
  out_beat_t         out_q, res;
  logic              have;
  logic              take;
  logic [7:0]        c;
  class_e            cl;
  logic [63:0]       acc_x10;

  assign tok_ready_o = !ovalid_q || out_ready_i;
  assign take        = tok_valid_i && tok_ready_o;
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;
  assign c           = tok_i.header_byte;
  assign cl          = tok_i.cls;
  assign acc_x10     = (acc_q << 3) + (acc_q << 1) + {60'd0, c[3:0]};

  // Next state: each mode handles its byte; continue cases are folded inline.
  always_comb begin
    logic [7:0] keep;
    logic [3:0] base;
    logic [3:0] cnt;
    logic       meta_go, field_go;
    mode_e      fv;
    mode_d = mode_q; depth_d = depth_q; acc_d = acc_q; start_d = start_q;
    len_d = len_q; pos_d = pos_q; cand_d = cand_q; esc_d = esc_q;
    seen_d = seen_q; dt_d = dt_q; rank_d = rank_q; dig_d = dig_q;
    res = '0; have = 1'b0; keep = '0; base = 4'd0; cnt = 4'd0;
    meta_go = 1'b0; field_go = 1'b0; fv = M_FIELDWAIT;
    if (mode_q == M_KEY) begin base = 4'd0; cnt = 4'd1; end
    else if (mode_q == M_FIELDNAME) begin base = 4'd1; cnt = 4'd3; end
    else begin base = 4'd4; cnt = 4'd5; end
    for (int i = 0; i < 5; i++) begin
      if (4'(i) < cnt && cand_q[i] && pos_q < word_len(base + 4'(i)) &&
          word_char(base + 4'(i), pos_q) == c) keep[i] = 1'b1;
    end

    unique case (mode_q)
      M_OPEN: begin
        if (cl == CL_LBRACE) mode_d = M_KEYWAIT;
        else if (cl != CL_BLANK) begin
          mode_d = M_ERR; have = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MALFORMED;
        end
      end
      M_KEYWAIT: begin
        if (cl == CL_RBRACE) begin mode_d = M_DONE; have = 1'b1; res.kind = KIND_DONE; end
        else if (cl == CL_QUOTE) begin
          pos_d = '0; cand_d = 8'h01; esc_d = 1'b0; mode_d = M_KEY;
        end else if (cl != CL_BLANK && cl != CL_COMMA) begin
          mode_d = M_ERR; have = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MALFORMED;
        end
      end
      M_KEY: begin
        if (esc_q || cl != CL_QUOTE && cl != CL_BSLASH) begin
          esc_d = 1'b0; cand_d = keep;
          if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
          have = 1'b1; res.kind = KIND_KEYBYTE; res.value = {56'd0, c};
        end else if (cl == CL_BSLASH) esc_d = 1'b1;
        else begin
          cand_d = {7'd0, cand_q[0] && pos_q == 4'd12};
          have = 1'b1; res.kind = KIND_KEYEND; res.is_metadata = cand_q[0] && pos_q == 4'd12;
          mode_d = M_KEYCOLON;
        end
      end
      M_KEYCOLON, M_KEYVAL: begin
        if (cl == CL_BLANK) ;
        else if (cl == CL_COLON && mode_q == M_KEYCOLON) mode_d = M_KEYVAL;
        else if (cand_q[0]) meta_go = 1'b1;
        else if (cl == CL_LBRACE) begin
          seen_d = '0; dt_d = '0; rank_d = '0; start_d = '0; len_d = '0; acc_d = '0;
          dig_d = 1'b0; mode_d = M_FIELDWAIT;
        end else begin
          mode_d = M_ERR; have = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MALFORMED;
        end
      end
      M_META: meta_go = 1'b1;
      M_FIELDWAIT, M_SKIPFIELD, M_FIELDCOLON, M_FIELDVAL, M_SHAPE, M_OFF_A, M_OFF_B,
      M_OFF_C, M_OFF_D: field_go = 1'b1;
      M_FIELDNAME: begin
        if (esc_q || cl != CL_QUOTE && cl != CL_BSLASH) begin
          esc_d = 1'b0; cand_d = keep;
          if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
        end else if (cl == CL_BSLASH) esc_d = 1'b1;
        else begin
          for (int i = 0; i < 3; i++) begin
            cand_d[i] = cand_q[i] && word_len(4'(i + 1)) == pos_q;
          end
          cand_d[7:3] = '0;
          mode_d = M_FIELDCOLON;
        end
      end
      M_DTYPESTR: begin
        if (esc_q || cl != CL_QUOTE && cl != CL_BSLASH) begin
          esc_d = 1'b0; cand_d = keep;
          if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
        end else if (cl == CL_BSLASH) esc_d = 1'b1;
        else begin
          for (int i = 0; i < 5; i++) begin
            cand_d[i] = cand_q[i] && word_len(4'(i + 4)) == pos_q;
          end
          cand_d[7:5] = '0;
          if (cand_d[4:0] == '0) begin
            mode_d = M_ERR; have = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_DTYPE;
          end else begin
            for (int i = 4; i >= 0; i--) if (cand_d[i]) dt_d = 3'(i);
            seen_d = seen_q | 3'b001; mode_d = M_FIELDWAIT;
          end
        end
      end
      default: ;
    endcase

    // Metadata brace counting.
    if (meta_go) begin
      mode_d = M_META;
      if (mode_q != M_META) depth_d = '0;
      if (cl == CL_LBRACE) begin
        if (mode_q == M_META && depth_q >= DepthW'(MaxSkipDepth)) begin
          mode_d = M_ERR; have = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MALFORMED;
        end else depth_d = (mode_q == M_META ? depth_q : '0) + 1'b1;
      end else if (cl == CL_RBRACE) begin
        if (mode_q != M_META || depth_q == '0) begin
          mode_d = M_ERR; have = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MALFORMED;
        end else begin
          depth_d = depth_q - 1'b1;
          if (depth_q == DepthW'(1)) mode_d = M_KEYWAIT;
        end
      end
    end

    // Tensor field handling; continue transitions chained in order.
    if (field_go) begin
      fv = mode_q;
      // Field value dispatch.
      if (fv == M_FIELDCOLON || fv == M_FIELDVAL) begin
        if (cl == CL_BLANK) fv = M_DONE;
        else if (cl == CL_COLON && fv == M_FIELDCOLON) begin mode_d = M_FIELDVAL; fv = M_DONE; end
        else if (cand_q[0]) begin
          if (cl == CL_QUOTE) begin
            pos_d = '0; cand_d = 8'h1F; esc_d = 1'b0; mode_d = M_DTYPESTR;
          end else begin
            mode_d = M_ERR; have = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_DTYPE;
          end
          fv = M_DONE;
        end else begin
          acc_d = '0; dig_d = 1'b0;
          if (cand_q[1]) begin
            rank_d = '0; mode_d = M_SHAPE;
            if (cl == CL_LBRACK) fv = M_DONE; else fv = M_SHAPE;
          end else if (cand_q[2]) begin
            mode_d = M_OFF_A;
            if (cl == CL_LBRACK) fv = M_DONE; else fv = M_OFF_A;
          end else fv = M_SKIPFIELD;
        end
      end
      if (fv == M_SHAPE) begin
        fv = M_DONE;
        if (cl == CL_DIGIT) begin
          acc_d = (mode_q == M_SHAPE ? acc_x10 : {60'd0, c[3:0]}); dig_d = 1'b1; mode_d = M_SHAPE;
        end else if (cl == CL_BLANK || cl == CL_COMMA || cl == CL_RBRACK) begin
          if (cl == CL_RBRACK) begin seen_d = seen_q | 3'b010; mode_d = M_FIELDWAIT; end
          if (mode_q == M_SHAPE && dig_q) begin
            have = 1'b1; res.kind = KIND_DIM; res.value = acc_q;
            if (rank_q != 8'd255) rank_d = rank_q + 8'd1;
            acc_d = '0; dig_d = 1'b0;
          end
        end else begin
          mode_d = M_ERR; have = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_MALFORMED;
        end
      end
      if (fv == M_OFF_A || fv == M_OFF_C) begin
        if (cl == CL_DIGIT) begin
          acc_d = (mode_q == fv ? acc_x10 : {60'd0, c[3:0]}); dig_d = 1'b1;
          mode_d = fv; fv = M_DONE;
        end else if (cl == CL_BLANK && !(mode_q == fv && dig_q)) begin
          mode_d = fv; fv = M_DONE;
        end else begin
          if (fv == M_OFF_A) begin
            start_d = (mode_q == fv) ? acc_q : '0; fv = M_OFF_B;
          end else begin
            len_d = ((mode_q == fv) ? acc_q : '0) - start_d;
            seen_d = seen_d | 3'b100; fv = M_OFF_D;
          end
          acc_d = '0; dig_d = 1'b0;
        end
      end
      if (fv == M_OFF_B) begin
        if (cl == CL_BLANK) begin mode_d = M_OFF_B; fv = M_DONE; end
        else begin
          mode_d = M_OFF_C;
          if (cl == CL_COMMA) fv = M_DONE; else fv = M_OFF_C;
        end
      end
      if (fv == M_OFF_C) begin
        // Only reached from OFF_B with a fresh accumulator.
        if (cl == CL_DIGIT) begin acc_d = {60'd0, c[3:0]}; dig_d = 1'b1; fv = M_DONE; end
        else if (cl == CL_BLANK) fv = M_DONE;
        else begin
          len_d = 64'd0 - start_d; seen_d = seen_d | 3'b100; acc_d = '0; dig_d = 1'b0;
          fv = M_OFF_D;
        end
      end
      if (fv == M_OFF_D) begin
        mode_d = M_FIELDWAIT;
        if (cl == CL_RBRACK) fv = M_DONE; else fv = M_FIELDWAIT;
      end
      if (fv == M_SKIPFIELD) begin
        fv = M_DONE;
        if (cl == CL_COMMA) mode_d = M_FIELDWAIT;
        else if (cl == CL_RBRACE) fv = M_KEYWAIT;
        else mode_d = M_SKIPFIELD;
      end
      if (fv == M_FIELDWAIT) begin
        fv = M_DONE;
        if (cl == CL_BLANK || cl == CL_COMMA) ;
        else if (cl == CL_RBRACE) fv = M_KEYWAIT;
        else if (cl == CL_QUOTE) begin
          pos_d = '0; cand_d = 8'h07; esc_d = 1'b0; mode_d = M_FIELDNAME;
        end else mode_d = M_SKIPFIELD;
      end
      // Tensor end record.
      if (fv == M_KEYWAIT) begin
        mode_d = M_KEYWAIT; have = 1'b1; res.kind = KIND_TENSOR; res.value = start_d;
        res.byte_count = len_d; res.dtype_code = dt_d; res.complete = (seen_d == 3'b111);
        res.rank = rank_d;
      end
    end

    // Last byte: early-end error and return to reset state.
    if (tok_i.last_byte) begin
      if (mode_q != M_DONE && mode_q != M_ERR &&
          !(have && (res.kind == KIND_DONE || res.kind == KIND_ERROR))) begin
        have = 1'b1; res = '0; res.kind = KIND_ERROR; res.error_code = ERR_EARLY_END;
      end
      mode_d = M_OPEN; depth_d = '0; acc_d = '0; start_d = '0; len_d = '0; pos_d = '0;
      cand_d = 8'hFF; esc_d = 1'b0; seen_d = '0; dt_d = '0; rank_d = '0; dig_d = 1'b0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_OPEN; depth_q <= '0; acc_q <= '0; start_q <= '0; len_q <= '0;
      pos_q <= '0; cand_q <= 8'hFF; esc_q <= 1'b0; seen_q <= '0; dt_q <= '0;
      rank_q <= '0; dig_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        mode_q <= mode_d; depth_q <= depth_d; acc_q <= acc_d; start_q <= start_d;
        len_q <= len_d; pos_q <= pos_d; cand_q <= cand_d; esc_q <= esc_d;
        seen_q <= seen_d; dt_q <= dt_d; rank_q <= rank_d; dig_q <= dig_d;
      end
      if (tok_ready_o) ovalid_q <= take && have;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (take && have) out_q <= res;
  end
endmodule : thjp_back
`default_nettype wire

[rtl/tensor_header_json_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tensor_header_json_parser: byte-serial tensor file header parser.
// Feed the header text one byte per beat on in_if (header_byte, last_byte).
// Records leave on out_if: key bytes, key end, shape dimensions, tensor end
// with offset, byte count, dtype, rank and completeness, header done, error.
// Each byte gives zero or one record. Throughput is one byte per cycle when
// nothing stalls; a byte passes the classifier register, a two-entry queue
// and the parser state machine, and its record leaves from the output
// register. The parser state register, updated once per byte, sets the
// rate. Reset clears all state; the parser waits for an opening brace.
// When the receiver stalls, the output register holds its record and the
// queue and classifier fill up before in_if drops ready. After the byte
// marked last_byte the parser returns to its reset state.
// ----------------------------------------------------------------------------
module tensor_header_json_parser #(
  parameter int unsigned MaxSkipDepth = thjp_pkg::DefaultMaxSkipDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  thjp_stream_if.sink   in_if,
  thjp_stream_if.source out_if
);
  import thjp_pkg::*;

  tok_t f_tok, q_tok;
  logic f_valid, f_ready, q_valid, q_ready;

  thjp_front u_front (
    .clk_i, .rst_ni,
    .in_i(in_if.payload), .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .tok_o(f_tok), .tok_valid_o(f_valid), .tok_ready_i(f_ready)
  );

  thjp_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_i(f_tok), .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .rd_o(q_tok), .rd_valid_o(q_valid), .rd_ready_i(q_ready)
  );

  thjp_back #(.MaxSkipDepth(MaxSkipDepth)) u_back (
    .clk_i, .rst_ni,
    .tok_i(q_tok), .tok_valid_i(q_valid), .tok_ready_o(q_ready),
    .out_o(out_if.payload), .out_valid_o(out_if.valid), .out_ready_i(out_if.ready)
  );

  // A stalled record must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.payload))
    else $error("record changed under stall");

  // Records only carry defined kinds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.payload.kind <= KIND_ERROR)
    else $error("bad record kind");

  // Error code is set exactly on error records.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> ((out_if.payload.kind == KIND_ERROR) == (out_if.payload.error_code != 2'd0)))
    else $error("error code mismatch");
endmodule : tensor_header_json_parser
`default_nettype wire

[dv/tensor_header_json_parser_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_header_json_parser_test: self-checking bench for the header parser.
// Streams directed and random JSON headers into the parser one byte per beat,
// predicts every record with a behavioral parser of its own, and compares
// each record that leaves against the oldest predicted one. Both channel
// sides idle at random in the first two of three phases; the last has no idling.
// ----------------------------------------------------------------------------
module tensor_header_json_parser_test;
  import thjp_pkg::*;

  localparam int unsigned SkipLimit = DefaultMaxSkipDepth;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TargetBytes = 1350;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  thjp_stream_if #(.payload_t(in_beat_t))  in_ch ();
  thjp_stream_if #(.payload_t(out_beat_t)) out_ch ();

  tensor_header_json_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Header bytes waiting to be sent and records predicted but not yet seen.
  in_beat_t  header_bytes[$];
  out_beat_t pending_records[$];
  int unsigned bytes_total;
  int unsigned bytes_accepted;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Known words: the metadata key, three field names, five dtype names.
  string known_word[9] = '{"__metadata__", "dtype", "shape", {"data_", "offsets"},
                           "BF16", "F32", "F16", "I32", "I64"};
  localparam int unsigned WordMeta = 0;
  localparam int unsigned WordField = 1;
  localparam int unsigned WordDtype = 4;

  // Parser state of the prediction.
  mode_e       pmode;
  int unsigned skip_lvl;
  logic [63:0] num_acc;
  logic [63:0] start_off;
  logic [63:0] data_len;
  logic [3:0]  match_pos;
  logic [7:0]  match_set;
  bit          esc_pending;
  logic [2:0]  seen_mask;
  logic [2:0]  dtype_cur;
  logic [7:0]  dim_cnt;
  bit          have_digit;
  bit          rec_valid;
  out_beat_t   rec;

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void parser_clear();
    pmode = M_OPEN;
    skip_lvl = 0;
    num_acc = '0;
    start_off = '0;
    data_len = '0;
    match_pos = '0;
    match_set = 8'hff;
    esc_pending = 1'b0;
    seen_mask = '0;
    dtype_cur = '0;
    dim_cnt = '0;
    have_digit = 1'b0;
  endfunction

  function void put_record(kind_e k, logic [63:0] v);
    rec = '0;
    rec.kind = k;
    rec.value = v;
    rec_valid = 1'b1;
  endfunction

  function void flag_error(err_e code);
    pmode = M_ERR;
    put_record(KIND_ERROR, '0);
    rec.error_code = code;
  endfunction

  function void match_start(int unsigned cnt);
    match_pos = '0;
    match_set = 8'((1 << cnt) - 1);
    esc_pending = 1'b0;
  endfunction

  function void match_step(int unsigned base, int unsigned cnt, logic [7:0] c);
    logic [7:0] keep;
    keep = '0;
    for (int i = 0; i < cnt; i++) begin
      if (match_set[i] && match_pos < known_word[base + i].len() &&
          known_word[base + i][match_pos] == c) keep[i] = 1'b1;
    end
    match_set = keep;
    if (match_pos < 4'd15) match_pos++;
  endfunction

  function logic [7:0] match_end(int unsigned base, int unsigned cnt);
    logic [7:0] keep;
    keep = '0;
    for (int i = 0; i < cnt; i++) begin
      if (match_set[i] && known_word[base + i].len() == match_pos) keep[i] = 1'b1;
    end
    return keep;
  endfunction

  // 0 content byte, 1 closing quote, 2 escape introducer.
  function int string_step(logic [7:0] c);
    if (esc_pending) begin
      esc_pending = 1'b0;
      return 0;
    end
    if (c == "\\") begin
      esc_pending = 1'b1;
      return 2;
    end
    if (c == "\"") return 1;
    return 0;
  endfunction

  function void close_tensor();
    put_record(KIND_TENSOR, start_off);
    rec.byte_count = data_len;
    rec.dtype_code = dtype_cur;
    rec.complete = (seen_mask == 3'd7);
    rec.rank = dim_cnt;
    pmode = M_KEYWAIT;
  endfunction

  function void emit_dim();
    put_record(KIND_DIM, num_acc);
    if (dim_cnt < 8'd255) dim_cnt++;
    num_acc = '0;
    have_digit = 1'b0;
  endfunction

  // Advances the parser by one byte; a mode change that reuses the byte loops.
  function void consume_byte(logic [7:0] c);
    int r;
    forever begin
      case (pmode)
        M_OPEN: begin
          if (is_blank(c)) return;
          if (c == "{") pmode = M_KEYWAIT;
          else flag_error(ERR_MALFORMED);
          return;
        end
        M_KEYWAIT: begin
          if (is_blank(c) || c == ",") return;
          if (c == "}") begin
            pmode = M_DONE;
            put_record(KIND_DONE, '0);
          end else if (c == "\"") begin
            match_start(1);
            pmode = M_KEY;
          end else flag_error(ERR_MALFORMED);
          return;
        end
        M_KEY: begin
          r = string_step(c);
          if (r == 2) return;
          if (r == 0) begin
            match_step(WordMeta, 1, c);
            put_record(KIND_KEYBYTE, {56'h0, c});
            return;
          end
          match_set = match_end(WordMeta, 1);
          put_record(KIND_KEYEND, '0);
          rec.is_metadata = match_set[0];
          pmode = M_KEYCOLON;
          return;
        end
        M_KEYCOLON, M_KEYVAL: begin
          if (is_blank(c)) return;
          if (c == ":" && pmode == M_KEYCOLON) begin
            pmode = M_KEYVAL;
            return;
          end
          if (match_set[0]) begin
            skip_lvl = 0;
            pmode = M_META;
            continue;
          end
          if (c == "{") begin
            seen_mask = '0;
            dtype_cur = '0;
            dim_cnt = '0;
            start_off = '0;
            data_len = '0;
            num_acc = '0;
            have_digit = 1'b0;
            pmode = M_FIELDWAIT;
          end else flag_error(ERR_MALFORMED);
          return;
        end
        M_META: begin
          if (c == "{") begin
            if (skip_lvl >= SkipLimit) flag_error(ERR_MALFORMED);
            else skip_lvl++;
          end else if (c == "}") begin
            if (skip_lvl == 0) flag_error(ERR_MALFORMED);
            else begin
              skip_lvl--;
              if (skip_lvl == 0) pmode = M_KEYWAIT;
            end
          end
          return;
        end
        M_FIELDWAIT: begin
          if (is_blank(c) || c == ",") return;
          if (c == "}") close_tensor();
          else if (c == "\"") begin
            match_start(3);
            pmode = M_FIELDNAME;
          end else pmode = M_SKIPFIELD;
          return;
        end
        M_SKIPFIELD: begin
          if (c == ",") pmode = M_FIELDWAIT;
          else if (c == "}") close_tensor();
          return;
        end
        M_FIELDNAME: begin
          r = string_step(c);
          if (r == 0) match_step(WordField, 3, c);
          else if (r == 1) begin
            match_set = match_end(WordField, 3);
            pmode = M_FIELDCOLON;
          end
          return;
        end
        M_FIELDCOLON, M_FIELDVAL: begin
          if (is_blank(c)) return;
          if (c == ":" && pmode == M_FIELDCOLON) begin
            pmode = M_FIELDVAL;
            return;
          end
          if (match_set[0]) begin
            if (c == "\"") begin
              match_start(5);
              pmode = M_DTYPESTR;
            end else flag_error(ERR_DTYPE);
            return;
          end
          num_acc = '0;
          have_digit = 1'b0;
          if (match_set[1]) begin
            dim_cnt = '0;
            pmode = M_SHAPE;
            if (c == "[") return;
            continue;
          end
          if (match_set[2]) begin
            pmode = M_OFF_A;
            if (c == "[") return;
            continue;
          end
          pmode = M_SKIPFIELD;
          continue;
        end
        M_DTYPESTR: begin
          r = string_step(c);
          if (r == 0) begin
            match_step(WordDtype, 5, c);
            return;
          end
          if (r == 2) return;
          match_set = match_end(WordDtype, 5);
          if (match_set == 0) begin
            flag_error(ERR_DTYPE);
            return;
          end
          for (int i = 4; i >= 0; i--) if (match_set[i]) dtype_cur = 3'(i);
          seen_mask[0] = 1'b1;
          pmode = M_FIELDWAIT;
          return;
        end
        M_SHAPE: begin
          if (is_digit(c)) begin
            num_acc = num_acc * 10 + 64'(c - "0");
            have_digit = 1'b1;
          end else if (is_blank(c) || c == ",") begin
            if (have_digit) emit_dim();
          end else if (c == "]") begin
            seen_mask[1] = 1'b1;
            pmode = M_FIELDWAIT;
            if (have_digit) emit_dim();
          end else flag_error(ERR_MALFORMED);
          return;
        end
        M_OFF_A, M_OFF_C: begin
          if (is_digit(c)) begin
            num_acc = num_acc * 10 + 64'(c - "0");
            have_digit = 1'b1;
            return;
          end
          if (is_blank(c) && !have_digit) return;
          if (pmode == M_OFF_A) begin
            start_off = num_acc;
            pmode = M_OFF_B;
          end else begin
            data_len = num_acc - start_off;
            seen_mask[2] = 1'b1;
            pmode = M_OFF_D;
          end
          num_acc = '0;
          have_digit = 1'b0;
          continue;
        end
        M_OFF_B: begin
          if (is_blank(c)) return;
          pmode = M_OFF_C;
          if (c == ",") return;
          continue;
        end
        M_OFF_D: begin
          pmode = M_FIELDWAIT;
          if (c == "]") return;
          continue;
        end
        default: return;
      endcase
    end
  endfunction

  // Predicts the record, if any, that one accepted beat produces.
  function void predict_record(in_beat_t b);
    bit stopped;
    stopped = (pmode == M_DONE || pmode == M_ERR);
    rec_valid = 1'b0;
    consume_byte(b.header_byte);
    if (b.last_byte) begin
      if (!stopped && !(rec_valid && (rec.kind == KIND_DONE || rec.kind == KIND_ERROR)))
        flag_error(ERR_EARLY_END);
      parser_clear();
    end
    if (rec_valid) pending_records.insert(pending_records.size(), rec);
  endfunction

  // Stimulus helpers.
  function void add_text(string s);
    in_beat_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.header_byte = s[i];
      b.last_byte = 1'b0;
      header_bytes.insert(header_bytes.size(), b);
    end
  endfunction

  function void add_header(string s);
    add_text(s);
    header_bytes[header_bytes.size() - 1].last_byte = 1'b1;
  endfunction

  function string rand_blank();
    case ($urandom_range(7))
      0: return " ";
      1: return "\t";
      2: return "\n\r ";
      default: return "";
    endcase
  endfunction

  function string rand_number();
    case ($urandom_range(9))
      0: return "0";
      1: return "18446744073709551615";
      2: return "99999999999999999999999";
      3: return $sformatf("%0d", $urandom());
      default: return $sformatf("%0d", $urandom_range(4096));
    endcase
  endfunction

  function string rand_tensor();
    string fields[$];
    string s;
    string dims;
    int n;
    case ($urandom_range(11))
      0: s = "BF16";
      1: s = "F32";
      2: s = "F16";
      3: s = "I32";
      4: s = "I64";
      5: s = "F64";
      6: s = "F3";
      default: s = known_word[WordDtype + $urandom_range(4)];
    endcase
    if ($urandom_range(15) != 0)
      fields.insert(fields.size(), {"\"dtype\":", rand_blank(), "\"", s, "\""});
    n = $urandom_range(4);
    dims = "";
    for (int i = 0; i < n; i++)
      dims = {dims, (i > 0) ? string'(",") : string'(""), rand_blank(), rand_number()};
    if ($urandom_range(15) != 0) fields.insert(fields.size(), {"\"shape\":[", dims, "]"});
    if ($urandom_range(15) != 0)
      fields.insert(fields.size(), {"\"data_", "offsets\":[", rand_number(), ",",
                                    rand_blank(), rand_number(), "]"});
    if ($urandom_range(5) == 0) fields.insert(fields.size(), {"\"extra\":", rand_number()});
    fields.shuffle();
    s = "{";
    foreach (fields[i])
      s = {s, (i > 0) ? string'(",") : string'(""), rand_blank(), fields[i]};
    return {s, "}"};
  endfunction

  // Mostly well-formed headers; some are damaged, cut short or followed by junk.
  function void add_random_header();
    string s;
    string key;
    int start;
    int n;
    start = header_bytes.size();
    s = {rand_blank(), "{"};
    if ($urandom_range(3) == 0) s = {s, "\"__metadata__\":{\"fmt\":{\"v\":\"pt\"}},"};
    n = $urandom_range(3);
    for (int t = 0; t < n; t++) begin
      key = "";
      for (int i = $urandom_range(1, 6); i > 0; i--)
        key = {key, string'(8'($urandom_range("a", "z")))};
      if ($urandom_range(7) == 0) key = {key, "\\\"q"};
      s = {s, (t > 0) ? string'(",") : string'(""), rand_blank(), "\"", key, "\"",
           ($urandom_range(9) == 0) ? string'("") : string'(":"), rand_blank(),
           rand_tensor()};
    end
    s = {s, rand_blank(), "}"};
    add_text(s);
    case ($urandom_range(9))
      0: header_bytes[start + $urandom_range(s.len() - 1)].header_byte = 8'($urandom());
      1: if (s.len() > 2) begin
        for (int i = $urandom_range(1, s.len() - 2); i > 0; i--) void'(header_bytes.pop_back());
      end
      2: add_text("  xx");
      default: ;
    endcase
    header_bytes[header_bytes.size() - 1].last_byte = 1'b1;
  endfunction

  // Sender side: next beat when the channel is free, unless it idles at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (header_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.payload <= header_bytes.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver side stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict on each accepted byte and check each accepted record.
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni) begin
      cycles++;
      if (in_ch.valid && in_ch.ready) begin
        predict_record(in_ch.payload);
        bytes_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected record: %p", out_ch.payload);
        end else begin
          want = pending_records.pop_front();
          if (out_ch.payload.kind != want.kind || out_ch.payload.value != want.value ||
              out_ch.payload.byte_count != want.byte_count ||
              out_ch.payload.dtype_code != want.dtype_code ||
              out_ch.payload.complete != want.complete ||
              out_ch.payload.rank != want.rank ||
              out_ch.payload.is_metadata != want.is_metadata ||
              out_ch.payload.error_code != want.error_code) begin
            mismatches++;
            if (mismatches <= 10)
              $display("record mismatch: expected %p actual %p", want, out_ch.payload);
          end
        end
      end
      if (cycles >= CycleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Idling phases follow progress through the byte stream.
  always @(posedge clk_i) begin
    if (bytes_accepted < bytes_total / 3) begin
      send_idle_pct <= 7;
      recv_stall_pct <= 72;
    end else if (bytes_accepted < 2 * bytes_total / 3) begin
      send_idle_pct <= 72;
      recv_stall_pct <= 7;
    end else begin
      send_idle_pct <= 0;
      recv_stall_pct <= 0;
    end
  end

  initial begin
    string deep;
    send_idle_pct = 7;
    recv_stall_pct = 72;
    parser_clear();

    // Directed headers: every dtype, metadata, escapes, odd layouts, errors.
    add_header({"{\"__metadata__\":{\"a\":{}},\"w\\\"1\":{\"dtype\":\"BF16\",",
                "\"shape\":[2, 3],\"data_", "offsets\":[0,12]},",
                "\"b\" {\"dtype\":\"F32\",\"shape\":[],\"shape\":[18446744073709551615]",
                ",\"junk\":[1,2],\"data_", "offsets\":[24,8]},",
                "\"c\":{\"dtype\":\"F16\"},\"d\":{\"dtype\":\"I32\",7,\"data_",
                "offsets\":[]},",
                "\"e\":{\"dtype\":\"I64\",\"shape\":[99999999999999999999,,1]}}"});
    add_header("x");
    add_header("{\"t\":{\"dtype\":\"Q8\"}}");
    add_header("{\"t\":{\"dtype\":5}}");
    add_header("{\"t\":{\"shape\":[1;2]}}");
    add_header("{\"t\":{\"dtype\":\"F32\"");
    add_header("{\"__metadata__\":}");
    add_header("{x}");
    add_header("{\"t\":5}");
    add_header("{} trailing");
    add_header("{");
    add_text("\t{\"\xff\x80\":{}}");
    header_bytes[header_bytes.size() - 1].last_byte = 1'b1;
    deep = "{\"__metadata__\":";
    for (int i = 0; i < 256; i++) deep = {deep, "{"};
    add_header(deep);

    // Random headers, plus the occasional byte of pure noise.
    while (header_bytes.size() < TargetBytes) begin
      if ($urandom_range(19) == 0) begin
        header_bytes.insert(header_bytes.size(),
                            in_beat_t'({8'($urandom()), 1'($urandom())}));
      end else begin
        add_random_header();
      end
    end
    bytes_total = header_bytes.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (header_bytes.size() > 0 || in_ch.valid || pending_records.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule : tensor_header_json_parser_test
